// File: rtl/core/pmm_pkg.sv
// Shared types and constants of the paged memory mapper.
// Used by every module of the mapper; depends on nothing.
package pmm_pkg;

  localparam int unsigned REGION_COUNT = 16;
  localparam int unsigned REGION_AW    = 4;
  localparam int unsigned OFFSET_W     = 12;
  localparam int unsigned WORD_W       = 16;
  localparam int unsigned PHYS_W       = 24;
  localparam int unsigned BANK_BITS_W  = 4;
  localparam int unsigned APB_AW       = 3;
  localparam int unsigned APB_DW       = 32;

  localparam logic [REGION_COUNT-1:0] SWAPPABLE = 16'hFC0C;

  localparam logic                   CARD_PRESENT_RST = 1'b1;
  localparam logic [BANK_BITS_W-1:0] BANK_BITS_RST    = 4'd8;

  localparam logic REG_IDX_CARD_PRESENT = 1'b0;
  localparam logic REG_IDX_BANK_BITS    = 1'b1;

  typedef enum logic [2:0] {
    ACT_CTRL_WR  = 3'd0,
    ACT_CTRL_RD  = 3'd1,
    ACT_PAGE_WR  = 3'd2,
    ACT_PAGE_RD  = 3'd3,
    ACT_XLATE    = 3'd4
  } pmm_action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_PAGE,
    ST_READ_MAP,
    ST_SWEEP_RD,
    ST_SWEEP_WR,
    ST_EMIT
  } pmm_state_e;

  typedef struct packed {
    logic                 we;
    logic                 re;
    logic [REGION_AW-1:0] addr;
  } pmm_mem_req_t;

  typedef struct packed {
    logic                   card_present;
    logic [BANK_BITS_W-1:0] bank_bits;
  } pmm_cfg_t;

endpackage

// File: rtl/core/pmm_cfg_regs.sv
// APB register file: card_present and bank_address_bits.
// Depends on pmm_pkg.
module pmm_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pmm_pkg::APB_AW-1:0]  paddr,
  input  logic [pmm_pkg::APB_DW-1:0]  pwdata,
  output logic [pmm_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output pmm_pkg::pmm_cfg_t           cfg_o
);

  logic                            card_present_q, card_present_d;
  logic [pmm_pkg::BANK_BITS_W-1:0] bank_bits_q, bank_bits_d;
  logic                            wr_en;
  logic                            reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_comb begin
    card_present_d = card_present_q;
    bank_bits_d    = bank_bits_q;
    if (wr_en) begin
      unique case (reg_idx)
        pmm_pkg::REG_IDX_CARD_PRESENT: card_present_d = pwdata[0];
        pmm_pkg::REG_IDX_BANK_BITS:    bank_bits_d = pwdata[pmm_pkg::BANK_BITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pmm_pkg::REG_IDX_CARD_PRESENT: prdata = pmm_pkg::APB_DW'(card_present_q);
      pmm_pkg::REG_IDX_BANK_BITS:    prdata = pmm_pkg::APB_DW'(bank_bits_q);
      default:                       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      card_present_q <= pmm_pkg::CARD_PRESENT_RST;
      bank_bits_q    <= pmm_pkg::BANK_BITS_RST;
    end else begin
      card_present_q <= card_present_d;
      bank_bits_q    <= bank_bits_d;
    end
  end

  assign cfg_o.card_present = card_present_q;
  assign cfg_o.bank_bits    = bank_bits_q;

endmodule

// File: rtl/core/pmm_region_mem.sv
// Sixteen-entry region store with a registered read.
// Unwritten entries read as their own index. Depends on pmm_pkg.
module pmm_region_mem #(
  parameter int unsigned WIDTH = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pmm_pkg::pmm_mem_req_t req_i,
  input  logic [WIDTH-1:0]     wdata_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0]                 mem_q [pmm_pkg::REGION_COUNT];
  logic [pmm_pkg::REGION_COUNT-1:0] valid_q;
  logic [WIDTH-1:0]                 rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= wdata_i;
    end
    if (req_i.re) begin
      rdata_q <= valid_q[req_i.addr] ? mem_q[req_i.addr] : WIDTH'(req_i.addr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.addr] <= 1'b1;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/pmm_ctrl.sv
// Sequencer of the mapper: control bits, action decode, remap pass and result register.
// Drives the page-register store and the bank map. Depends on pmm_pkg.
module pmm_ctrl #(
  parameter int unsigned BANK_WIDTH = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pmm_pkg::pmm_cfg_t             cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    action_i,
  input  logic [pmm_pkg::WORD_W-1:0]    address_i,
  input  logic [pmm_pkg::WORD_W-1:0]    data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pmm_pkg::WORD_W-1:0]    read_data_o,
  output logic [pmm_pkg::PHYS_W-1:0]    phys_addr_o,
  output pmm_pkg::pmm_mem_req_t         page_req_o,
  output logic [BANK_WIDTH-1:0]         page_wdata_o,
  input  logic [BANK_WIDTH-1:0]         page_rdata_i,
  output pmm_pkg::pmm_mem_req_t         map_req_o,
  output logic [BANK_WIDTH-1:0]         map_wdata_o,
  input  logic [BANK_WIDTH-1:0]         map_rdata_i
);

  pmm_pkg::pmm_state_e               state_q, state_d;
  logic                              regs_visible_q, regs_visible_d;
  logic                              map_enable_q, map_enable_d;
  logic [pmm_pkg::REGION_AW-1:0]     cnt_q, cnt_d;
  logic [pmm_pkg::OFFSET_W-1:0]      offset_q, offset_d;
  logic                              out_valid_q, out_valid_d;
  logic [pmm_pkg::WORD_W-1:0]        read_data_q, read_data_d;
  logic [pmm_pkg::PHYS_W-1:0]        phys_addr_q, phys_addr_d;
  logic [BANK_WIDTH-1:0]             bank_mask;
  logic                              slot_free;
  logic                              accept;
  logic [pmm_pkg::REGION_AW-1:0]     reg_region;
  logic                              sweep_last;

  always_comb begin
    for (int i = 0; i < BANK_WIDTH; i++) begin
      bank_mask[i] = (i < int'(cfg_i.bank_bits));
    end
  end

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == pmm_pkg::ST_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;
  assign reg_region = address_i[4:1];
  assign sweep_last = (cnt_q == pmm_pkg::REGION_AW'(pmm_pkg::REGION_COUNT - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pmm_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (pmm_pkg::pmm_action_e'(action_i))
            pmm_pkg::ACT_CTRL_WR: begin
              if (cfg_i.card_present && address_i[0]) state_d = pmm_pkg::ST_SWEEP_RD;
            end
            pmm_pkg::ACT_PAGE_RD: state_d = pmm_pkg::ST_READ_PAGE;
            pmm_pkg::ACT_XLATE:   state_d = pmm_pkg::ST_READ_MAP;
            default: ;
          endcase
        end
      end
      pmm_pkg::ST_READ_PAGE: if (slot_free) state_d = pmm_pkg::ST_IDLE;
      pmm_pkg::ST_READ_MAP:  if (slot_free) state_d = pmm_pkg::ST_IDLE;
      pmm_pkg::ST_SWEEP_RD:  state_d = pmm_pkg::ST_SWEEP_WR;
      pmm_pkg::ST_SWEEP_WR:  state_d = sweep_last ? pmm_pkg::ST_EMIT : pmm_pkg::ST_SWEEP_RD;
      pmm_pkg::ST_EMIT:      if (slot_free) state_d = pmm_pkg::ST_IDLE;
      default:               state_d = pmm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    regs_visible_d = regs_visible_q;
    map_enable_d   = map_enable_q;
    cnt_d          = cnt_q;
    offset_d       = offset_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    read_data_d    = read_data_q;
    phys_addr_d    = phys_addr_q;
    page_req_o     = '0;
    page_wdata_o   = data_i[BANK_WIDTH-1:0];
    map_req_o      = '0;
    map_wdata_o    = data_i[BANK_WIDTH-1:0] & bank_mask;
    unique case (state_q)
      pmm_pkg::ST_IDLE: begin
        if (accept) begin
          read_data_d = '0;
          phys_addr_d = '0;
          out_valid_d = 1'b1;
          unique case (pmm_pkg::pmm_action_e'(action_i))
            pmm_pkg::ACT_CTRL_WR: begin
              if (cfg_i.card_present) begin
                if (address_i[0]) begin
                  map_enable_d = data_i[0];
                  cnt_d        = '0;
                  out_valid_d  = out_valid_q && !out_ready_i;
                end else begin
                  regs_visible_d = data_i[0];
                end
              end
            end
            pmm_pkg::ACT_CTRL_RD: begin
              if (!cfg_i.card_present) begin
                read_data_d = pmm_pkg::WORD_W'(1'b1);
              end else begin
                read_data_d = pmm_pkg::WORD_W'(address_i[0] ? map_enable_q : regs_visible_q);
              end
            end
            pmm_pkg::ACT_PAGE_WR: begin
              if (regs_visible_q) begin
                page_req_o.we   = 1'b1;
                page_req_o.addr = reg_region;
                if (map_enable_q && pmm_pkg::SWAPPABLE[reg_region]) begin
                  map_req_o.we   = 1'b1;
                  map_req_o.addr = reg_region;
                end
              end
            end
            pmm_pkg::ACT_PAGE_RD: begin
              page_req_o.re   = 1'b1;
              page_req_o.addr = reg_region;
              out_valid_d     = out_valid_q && !out_ready_i;
            end
            pmm_pkg::ACT_XLATE: begin
              map_req_o.re   = 1'b1;
              map_req_o.addr = address_i[15:12];
              offset_d       = address_i[pmm_pkg::OFFSET_W-1:0];
              out_valid_d    = out_valid_q && !out_ready_i;
            end
            default: ;
          endcase
        end
      end
      pmm_pkg::ST_READ_PAGE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          read_data_d = {page_rdata_i[7:0], page_rdata_i[7:0]};
          phys_addr_d = '0;
        end
      end
      pmm_pkg::ST_READ_MAP: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          read_data_d = '0;
          phys_addr_d = pmm_pkg::PHYS_W'({map_rdata_i, offset_q});
        end
      end
      pmm_pkg::ST_SWEEP_RD: begin
        page_req_o.re   = 1'b1;
        page_req_o.addr = cnt_q;
      end
      pmm_pkg::ST_SWEEP_WR: begin
        map_req_o.addr = cnt_q;
        map_req_o.we   = pmm_pkg::SWAPPABLE[cnt_q];
        map_wdata_o    = (map_enable_q ? page_rdata_i : BANK_WIDTH'(cnt_q)) & bank_mask;
        cnt_d          = cnt_q + 1'b1;
      end
      pmm_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          read_data_d = '0;
          phys_addr_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= pmm_pkg::ST_IDLE;
      regs_visible_q <= 1'b0;
      map_enable_q   <= 1'b0;
      cnt_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      regs_visible_q <= regs_visible_d;
      map_enable_q   <= map_enable_d;
      cnt_q          <= cnt_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    offset_q    <= offset_d;
    read_data_q <= read_data_d;
    phys_addr_q <= phys_addr_d;
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign phys_addr_o = phys_addr_q;

endmodule

// File: rtl/core/paged_memory_mapper_top.sv
// Top level of the paged memory mapper: register file, sequencer and two region stores.
// Depends on pmm_pkg, pmm_cfg_regs, pmm_region_mem and pmm_ctrl.
//
// One item is in flight at a time, and each gives one result through an output
// register. A new item is taken only when that register is empty or its result
// leaves in the same cycle, so a waiting result holds off the input. Control reads,
// control writes to the visibility bit or with the card absent, page-register writes
// and unused actions load their result in the accepting cycle; page-register reads and
// translates wait in a read state for the registered read of the page store or the
// bank map and for a free output register. A write to the enable bit with the card
// present runs the accepting cycle, a remap pass over the sixteen regions (read of the
// page store, then write of the bank map for swappable regions) and an emit state that
// raises its result. Both stores read as their own index after reset, with no clearing pass.
module paged_memory_mapper_top #(
  parameter int unsigned BANK_WIDTH = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pmm_pkg::APB_AW-1:0]   paddr,
  input  logic [pmm_pkg::APB_DW-1:0]   pwdata,
  output logic [pmm_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   action_i,
  input  logic [pmm_pkg::WORD_W-1:0]   address_i,
  input  logic [pmm_pkg::WORD_W-1:0]   data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [pmm_pkg::WORD_W-1:0]   read_data_o,
  output logic [pmm_pkg::PHYS_W-1:0]   phys_addr_o
);

  pmm_pkg::pmm_cfg_t     cfg;
  pmm_pkg::pmm_mem_req_t page_req;
  pmm_pkg::pmm_mem_req_t map_req;
  logic [BANK_WIDTH-1:0] page_wdata, page_rdata;
  logic [BANK_WIDTH-1:0] map_wdata, map_rdata;

  pmm_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pmm_region_mem #(.WIDTH(BANK_WIDTH)) u_page_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (page_req),
    .wdata_i (page_wdata),
    .rdata_o (page_rdata)
  );

  pmm_region_mem #(.WIDTH(BANK_WIDTH)) u_map_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (map_req),
    .wdata_i (map_wdata),
    .rdata_o (map_rdata)
  );

  pmm_ctrl #(.BANK_WIDTH(BANK_WIDTH)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .address_i    (address_i),
    .data_i       (data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_data_o  (read_data_o),
    .phys_addr_o  (phys_addr_o),
    .page_req_o   (page_req),
    .page_wdata_o (page_wdata),
    .page_rdata_i (page_rdata),
    .map_req_o    (map_req),
    .map_wdata_o  (map_wdata),
    .map_rdata_i  (map_rdata)
  );

endmodule

// File: sim/pmm_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the paged memory mapper: mirrors the mapper state from observed
// transfers and configuration writes, and compares every result. Depends on pmm_pkg.
module pmm_result_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [pmm_pkg::APB_AW-1:0] paddr,
  input  logic [pmm_pkg::APB_DW-1:0] pwdata,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [2:0]                 action_i,
  input  logic [pmm_pkg::WORD_W-1:0] address_i,
  input  logic [pmm_pkg::WORD_W-1:0] data_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [pmm_pkg::WORD_W-1:0] read_data_i,
  input  logic [pmm_pkg::PHYS_W-1:0] phys_addr_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         checked_o
);
  import pmm_pkg::*;

  localparam int BANK_W = 12;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic [PHYS_W-1:0] phys_addr;
  } reply_t;

  reply_t                 pending_replies[$];
  reply_t                 oldest;
  logic                   card_present;
  logic [BANK_BITS_W-1:0] bank_bits;
  logic                   regs_visible;
  logic                   map_enable;
  logic [BANK_W-1:0]      page_regs   [REGION_COUNT];
  logic [BANK_W-1:0]      mapped_bank [REGION_COUNT];

  function automatic logic [BANK_W-1:0] bank_mask();
    int bits;
    bits = (bank_bits > BANK_W) ? BANK_W : int'(bank_bits);
    return BANK_W'((1 << bits) - 1);
  endfunction

  function automatic reply_t predict_reply(logic [2:0] act, logic [WORD_W-1:0] addr,
                                           logic [WORD_W-1:0] dat);
    reply_t            r;
    logic [3:0]        region;
    logic [7:0]        low_byte;
    r = '0;
    case (act)
      ACT_CTRL_WR: begin
        if (card_present) begin
          if (addr[0]) begin
            map_enable = dat[0];
            for (int i = 0; i < REGION_COUNT; i++) begin
              if (SWAPPABLE[i]) begin
                mapped_bank[i] = (map_enable ? page_regs[i] : BANK_W'(i)) & bank_mask();
              end
            end
          end else begin
            regs_visible = dat[0];
          end
        end
      end
      ACT_CTRL_RD: begin
        if (card_present) begin
          r.read_data = WORD_W'(addr[0] ? map_enable : regs_visible);
        end else begin
          r.read_data = WORD_W'(1);
        end
      end
      ACT_PAGE_WR: begin
        if (regs_visible) begin
          region = addr[4:1];
          if (map_enable && SWAPPABLE[region]) begin
            mapped_bank[region] = dat[BANK_W-1:0] & bank_mask();
          end
          page_regs[region] = dat[BANK_W-1:0];
        end
      end
      ACT_PAGE_RD: begin
        low_byte = page_regs[addr[4:1]][7:0];
        r.read_data = {low_byte, low_byte};
      end
      ACT_XLATE: begin
        r.phys_addr = {mapped_bank[addr[15:12]], addr[11:0]};
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    checked_o    = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      card_present = CARD_PRESENT_RST;
      bank_bits    = BANK_BITS_RST;
      regs_visible = 1'b0;
      map_enable   = 1'b0;
      for (int i = 0; i < REGION_COUNT; i++) begin
        page_regs[i]   = BANK_W'(i);
        mapped_bank[i] = BANK_W'(i);
      end
      pending_replies.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_replies.size() == 0) begin
          report_mismatch("unexpected transfer, phys_addr", 32'(phys_addr_i), 32'd0);
        end else begin
          oldest = pending_replies.pop_front();
          if (read_data_i !== oldest.read_data) begin
            report_mismatch("read_data", 32'(read_data_i), 32'(oldest.read_data));
          end
          if (phys_addr_i !== oldest.phys_addr) begin
            report_mismatch("phys_addr", 32'(phys_addr_i), 32'(oldest.phys_addr));
          end
          checked_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        pending_replies.push_back(predict_reply(action_i, address_i, data_i));
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[APB_AW-1:2] == REG_IDX_CARD_PRESENT) begin
          card_present = pwdata[0];
        end else if (paddr[APB_AW-1:2] == REG_IDX_BANK_BITS) begin
          bank_bits = pwdata[BANK_BITS_W-1:0];
        end
      end
      pending_o = pending_replies.size();
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Top of the paged memory mapper testbench: clock, reset, stimulus and verdict.
// Depends on pmm_pkg, paged_memory_mapper_top and pmm_result_checker.
module testbench;
  import pmm_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 40;
  localparam int PHASE_COUNT     = 8;
  localparam int PHASE_ITEMS     = 60;

  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [APB_AW-1:0]   paddr       = '0;
  logic [APB_DW-1:0]   pwdata      = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [2:0]          action_i    = '0;
  logic [WORD_W-1:0]   address_i   = '0;
  logic [WORD_W-1:0]   data_i      = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [WORD_W-1:0]   read_data_o;
  logic [PHYS_W-1:0]   phys_addr_o;

  int fail_count;
  int pending_count;
  int checked_count;
  int cycle_count   = 0;
  int n_items       = 0;
  int n_xlate       = 0;
  int n_page_wr     = 0;
  int n_ctrl_wr     = 0;
  int n_settings    = 0;
  bit tx_calm       = 1'b0;
  bit rx_calm       = 1'b0;
  bit hold_off_req  = 1'b0;

  always #5 clk_i = ~clk_i;

  paged_memory_mapper_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .address_i   (address_i),
    .data_i      (data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_data_o (read_data_o),
    .phys_addr_o (phys_addr_o)
  );

  pmm_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .action_i     (action_i),
    .address_i    (address_i),
    .data_i       (data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_data_i  (read_data_o),
    .phys_addr_i  (phys_addr_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_count),
    .checked_o    (checked_count)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  task automatic apb_write(logic reg_idx, logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(reg_idx) << 2;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    n_settings++;
  endtask

  task automatic issue(logic [2:0] act, logic [WORD_W-1:0] addr, logic [WORD_W-1:0] dat);
    int gap;
    gap = 0;
    if (!tx_calm && $urandom_range(0, 1) == 1) begin
      gap = idle_len();
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    address_i  <= addr;
    data_i     <= dat;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    n_items++;
    if (act == ACT_XLATE) n_xlate++;
    if (act == ACT_PAGE_WR) n_page_wr++;
    if (act == ACT_CTRL_WR) n_ctrl_wr++;
  endtask

  task automatic drain(int settle);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_count != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (!rx_calm && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat (idle_len()) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat (rx_calm ? 20 : $urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [2:0]        act;
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] dat;
    logic              card;
    logic [3:0]        bits;
    int                sel;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset state, hidden registers, control bit masking, mapping on and off
    issue(ACT_CTRL_RD, 16'h0000, 16'hFFFF);
    issue(ACT_CTRL_RD, 16'h0001, 16'h0000);
    issue(ACT_XLATE,   16'h0000, 16'h0000);
    issue(ACT_XLATE,   16'hFFFF, 16'hFFFF);
    issue(ACT_PAGE_RD, 16'h001E, 16'h0000);
    issue(ACT_PAGE_WR, 16'h0006, 16'hFFFF);
    issue(ACT_CTRL_WR, 16'h0000, 16'hFFFE);
    issue(ACT_CTRL_WR, 16'hFFFE, 16'h0001);
    issue(ACT_PAGE_WR, 16'h0014, 16'hFFFF);
    issue(ACT_PAGE_WR, 16'h0000, 16'hABCD);
    issue(ACT_PAGE_RD, 16'hFFE0, 16'h0000);
    issue(ACT_CTRL_WR, 16'h0001, 16'h0001);
    issue(ACT_XLATE,   16'hA123, 16'h0000);
    issue(ACT_XLATE,   16'h0456, 16'h0000);
    issue(ACT_PAGE_WR, 16'h0006, 16'h8081);
    issue(ACT_XLATE,   16'h3FFF, 16'h0000);
    issue(ACT_CTRL_RD, 16'hFFFF, 16'h0000);
    issue(ACT_SPARE_FIRST, 16'hFFFF, 16'hFFFF);
    issue(3'd6,        16'h5A5A, 16'hA5A5);
    issue(ACT_SPARE_LAST, 16'h0001, 16'h0001);
    issue(ACT_CTRL_WR, 16'h0001, 16'h0000);
    issue(ACT_XLATE,   16'hFFFF, 16'h0000);
    issue(ACT_PAGE_RD, 16'h0014, 16'h0000);
    issue(ACT_CTRL_WR, 16'h0000, 16'h0000);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain(SETTLE_CYCLES);
      card = !(p == 2 || p == 5);
      case (p)
        0:       bits = 4'd7;
        1:       bits = 4'd12;
        2:       bits = 4'd12;
        3:       bits = 4'd0;
        4:       bits = 4'd15;
        5:       bits = 4'd8;
        6:       bits = 4'd3;
        default: bits = 4'd8;
      endcase
      apb_write(REG_IDX_CARD_PRESENT, APB_DW'(card));
      apb_write(REG_IDX_BANK_BITS, APB_DW'(bits));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 20 == 0) begin
          tx_calm = ($urandom_range(0, 3) == 0);
          rx_calm = ($urandom_range(0, 3) == 0);
        end
        if (p == 1 && k == 10) begin
          tx_calm      = 1'b1;
          rx_calm      = 1'b0;
          hold_off_req = 1'b1;
        end
        sel  = $urandom_range(0, 99);
        addr = WORD_W'($urandom_range(0, 16'hFFFF));
        dat  = WORD_W'($urandom_range(0, 16'hFFFF));
        if (sel < 10) begin
          act    = ACT_CTRL_WR;
          dat[0] = ($urandom_range(0, 3) != 0);
        end else if (sel < 16) begin
          act = ACT_CTRL_RD;
        end else if (sel < 46) begin
          act = ACT_PAGE_WR;
        end else if (sel < 60) begin
          act = ACT_PAGE_RD;
        end else if (sel < 95) begin
          act = ACT_XLATE;
        end else begin
          act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
        end
        issue(act, addr, dat);
      end
    end

    drain(DRAIN_CYCLES);
    $display("run covered %0d transfers (%0d translates, %0d page writes, %0d control writes)",
             n_items, n_xlate, n_page_wr, n_ctrl_wr);
    $display("%0d results compared across %0d register writes", checked_count, n_settings);
    if (fail_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
